FILE: hw/rtl/spr_pkg.sv
// Shared types and constants for the stream pattern replace block.
// Used by spr_seq, spr_dp, stream_pattern_replace_unit and the testbench files; no dependencies.
`default_nettype none

package spr_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IN_TDATA_W = 40;  // word + slot, padded to whole bytes

  typedef enum logic [FUNC_W-1:0] {
    FN_ELEM   = 2'd0,
    FN_END    = 2'd1,
    FN_WR_PAT = 2'd2,
    FN_WR_REP = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    CFG_PLEN = 1'b0,
    CFG_RLEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_REP  = 2'd0,
    SRC_WIN  = 2'd1,
    SRC_WORD = 2'd2
  } src_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CMP_RD  = 6'b000010,
    ST_CMP_CHK = 6'b000100,
    ST_DECIDE  = 6'b001000,
    ST_SEL     = 6'b010000,
    ST_WAIT    = 6'b100000
  } state_e;

  // Sequencer to datapath strobes
  typedef struct packed {
    logic win_we;
    logic win_re;
    logic pat_we;
    logic pat_re;
    logic rep_we;
    logic rep_re;
    logic word_ld;
    logic cmp_init;
    logic cmp_step;
    src_e src;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spr_dp.sv
// Datapath: window, pattern and replacement memories, shared word comparator,
// beat value select. Depends on spr_pkg.
`default_nettype none

module spr_dp #(
  parameter int unsigned MAX_PATTERN     = 16,
  parameter int unsigned MAX_REPLACEMENT = 16,
  localparam int unsigned PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int unsigned PCW = $clog2(MAX_PATTERN + 1),
  localparam int unsigned RIW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1
) (
  input  wire                                  clk_i,
  input  spr_pkg::ctrl_t                       ctrl_i,
  input  wire  [PIW-1:0]                       head_i,
  input  wire  [PCW-1:0]                       win_off_i,
  input  wire  [PIW-1:0]                       pat_idx_i,
  input  wire  [RIW-1:0]                       rep_idx_i,
  input  wire  [spr_pkg::SLOT_W-1:0]           slot_i,
  input  wire  signed [spr_pkg::WORD_W-1:0]    word_i,
  output logic                                 match_o,
  output logic signed [spr_pkg::WORD_W-1:0]    value_o
);

  logic [spr_pkg::WORD_W-1:0] win_mem [MAX_PATTERN];
  logic [spr_pkg::WORD_W-1:0] pat_mem [MAX_PATTERN];
  logic [spr_pkg::WORD_W-1:0] rep_mem [MAX_REPLACEMENT];

  logic [spr_pkg::WORD_W-1:0] win_rd_q;
  logic [spr_pkg::WORD_W-1:0] pat_rd_q;
  logic [spr_pkg::WORD_W-1:0] rep_rd_q;
  logic [spr_pkg::WORD_W-1:0] word_q;
  logic                       match_q;

  logic [PCW:0]   win_sum;
  logic [PCW:0]   win_pos;
  logic [PIW-1:0] win_addr;
  logic           pat_slot_ok;
  logic           rep_slot_ok;
  logic [PIW-1:0] pat_slot;
  logic [RIW-1:0] rep_slot;

  // Circular window: position = (head + offset) mod depth, offset < depth
  assign win_sum  = (PCW + 1)'(head_i) + (PCW + 1)'(win_off_i);
  assign win_pos  = (win_sum >= (PCW + 1)'(MAX_PATTERN)) ?
                    win_sum - (PCW + 1)'(MAX_PATTERN) : win_sum;
  assign win_addr = win_pos[PIW-1:0];

  // Drop table writes beyond the table depth
  assign pat_slot_ok = 32'(slot_i) < MAX_PATTERN;
  assign rep_slot_ok = 32'(slot_i) < MAX_REPLACEMENT;
  assign pat_slot    = PIW'(slot_i);
  assign rep_slot    = RIW'(slot_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.win_we) begin
      win_mem[win_addr] <= word_i;
    end
    if (ctrl_i.win_re) begin
      win_rd_q <= win_mem[win_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_we && pat_slot_ok) begin
      pat_mem[pat_slot] <= word_i;
    end
    if (ctrl_i.pat_re) begin
      pat_rd_q <= pat_mem[pat_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rep_we && rep_slot_ok) begin
      rep_mem[rep_slot] <= word_i;
    end
    if (ctrl_i.rep_re) begin
      rep_rd_q <= rep_mem[rep_idx_i];
    end
  end

  // Shared comparator: fold one word pair per step into the match flag
  always_ff @(posedge clk_i) begin
    if (ctrl_i.word_ld) begin
      word_q <= word_i;
    end
    if (ctrl_i.cmp_init) begin
      match_q <= 1'b1;
    end else if (ctrl_i.cmp_step) begin
      match_q <= match_q & (win_rd_q == pat_rd_q);
    end
  end

  assign match_o = match_q;

  always_comb begin
    case (ctrl_i.src)
      spr_pkg::SRC_REP:  value_o = rep_rd_q;
      spr_pkg::SRC_WIN:  value_o = win_rd_q;
      spr_pkg::SRC_WORD: value_o = word_q;
      default:           value_o = word_q;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spr_seq.sv
// Sequencer: configuration registers, window fill and head, compare loop and
// beat emission order. Depends on spr_pkg.
`default_nettype none

module spr_seq #(
  parameter int unsigned MAX_PATTERN     = 16,
  parameter int unsigned MAX_REPLACEMENT = 16,
  localparam int unsigned PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int unsigned PCW = $clog2(MAX_PATTERN + 1),
  localparam int unsigned RIW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1,
  localparam int unsigned RCW = $clog2(MAX_REPLACEMENT + 1)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [0:0]                  cfg_idx_i,
  input  wire  [spr_pkg::LEN_W-1:0]   cfg_data_i,
  input  wire                         in_valid_i,
  input  spr_pkg::func_e              in_func_i,
  output logic                        in_ready_o,
  input  wire                         out_free_i,
  output logic                        push_o,
  output logic                        last_o,
  output logic                        flush_o,
  input  wire                         match_i,
  output spr_pkg::ctrl_t              ctrl_o,
  output logic [PIW-1:0]              head_o,
  output logic [PCW-1:0]              win_off_o,
  output logic [PIW-1:0]              pat_idx_o,
  output logic [RIW-1:0]              rep_idx_o
);

  spr_pkg::state_e state_q, state_d;
  spr_pkg::src_e   src_q, src_d;

  logic [spr_pkg::LEN_W-1:0] plen_q, plen_d;
  logic [spr_pkg::LEN_W-1:0] rlen_q, rlen_d;
  logic [PCW-1:0] fill_q, fill_d;
  logic [PIW-1:0] head_q, head_d;
  logic           ins_q, ins_d;
  logic [PCW-1:0] win_k_q, win_k_d;
  logic [PCW-1:0] win_cnt_q, win_cnt_d;
  logic [RCW-1:0] rep_k_q, rep_k_d;
  logic [RCW-1:0] rep_cnt_q, rep_cnt_d;
  logic           word_pend_q, word_pend_d;
  logic           flush_q, flush_d;
  logic           adv_q, adv_d;
  logic           last_q, last_d;

  logic [PCW-1:0] plen_eff;
  logic [RCW-1:0] rlen_eff;
  logic [PCW-1:0] fill_eff;
  logic [PCW-1:0] fill_inc;
  logic [PCW-1:0] head_sum;
  logic [PIW-1:0] head_adv;
  logic [PCW-1:0] win_k_inc;
  logic [RCW-1:0] rep_k_inc;

  // Clamp lengths to the table depths
  assign plen_eff = (32'(plen_q) > MAX_PATTERN) ? PCW'(MAX_PATTERN) : PCW'(plen_q);
  assign rlen_eff = (32'(rlen_q) > MAX_REPLACEMENT) ? RCW'(MAX_REPLACEMENT)
                                                    : RCW'(rlen_q);

  assign fill_eff  = (fill_q >= plen_eff) ? '0 : fill_q;
  assign fill_inc  = fill_eff + PCW'(1);
  assign head_sum  = PCW'(head_q) + PCW'(1);
  assign head_adv  = (head_sum == PCW'(MAX_PATTERN)) ? '0 : head_sum[PIW-1:0];
  assign win_k_inc = win_k_q + PCW'(1);
  assign rep_k_inc = rep_k_q + RCW'(1);

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    plen_d      = plen_q;
    rlen_d      = rlen_q;
    fill_d      = fill_q;
    head_d      = head_q;
    ins_d       = ins_q;
    win_k_d     = win_k_q;
    win_cnt_d   = win_cnt_q;
    rep_k_d     = rep_k_q;
    rep_cnt_d   = rep_cnt_q;
    word_pend_d = word_pend_q;
    flush_d     = flush_q;
    adv_d       = adv_q;
    last_d      = last_q;
    ctrl_o      = '0;
    ctrl_o.src  = src_q;
    win_off_o   = win_k_q;
    push_o      = 1'b0;

    case (state_q)
      spr_pkg::ST_IDLE: begin
        win_off_o = fill_eff;
        if (in_valid_i) begin
          case (in_func_i)
            spr_pkg::FN_WR_PAT: ctrl_o.pat_we = 1'b1;
            spr_pkg::FN_WR_REP: ctrl_o.rep_we = 1'b1;
            spr_pkg::FN_END: begin
              // Flush: pending front insertion, then the window, oldest first
              rep_cnt_d   = (plen_eff == '0 && !ins_q) ? rlen_eff : '0;
              win_cnt_d   = fill_q;
              word_pend_d = 1'b0;
              flush_d     = 1'b1;
              adv_d       = 1'b0;
              rep_k_d     = '0;
              win_k_d     = '0;
              fill_d      = '0;
              ins_d       = 1'b0;
              state_d     = spr_pkg::ST_SEL;
            end
            spr_pkg::FN_ELEM: begin
              if (plen_eff == '0) begin
                // Empty pattern: insert the replacement once, then pass the word
                rep_cnt_d      = ins_q ? '0 : rlen_eff;
                win_cnt_d      = '0;
                word_pend_d    = 1'b1;
                flush_d        = 1'b0;
                adv_d          = 1'b0;
                rep_k_d        = '0;
                win_k_d        = '0;
                ins_d          = 1'b1;
                ctrl_o.word_ld = 1'b1;
                state_d        = spr_pkg::ST_SEL;
              end else begin
                ctrl_o.win_we = 1'b1;
                fill_d        = fill_inc;
                if (fill_inc == plen_eff) begin
                  ctrl_o.cmp_init = 1'b1;
                  win_k_d         = '0;
                  state_d         = spr_pkg::ST_CMP_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      spr_pkg::ST_CMP_RD: begin
        ctrl_o.win_re = 1'b1;
        ctrl_o.pat_re = 1'b1;
        state_d       = spr_pkg::ST_CMP_CHK;
      end

      spr_pkg::ST_CMP_CHK: begin
        ctrl_o.cmp_step = 1'b1;
        if (win_k_inc == plen_eff) begin
          state_d = spr_pkg::ST_DECIDE;
        end else begin
          win_k_d = win_k_inc;
          state_d = spr_pkg::ST_CMP_RD;
        end
      end

      spr_pkg::ST_DECIDE: begin
        win_k_d     = '0;
        rep_k_d     = '0;
        word_pend_d = 1'b0;
        flush_d     = 1'b0;
        if (match_i) begin
          rep_cnt_d = rlen_eff;
          win_cnt_d = '0;
          fill_d    = '0;
          adv_d     = 1'b0;
        end else begin
          // Pass the oldest word on, then drop it from the window
          rep_cnt_d = '0;
          win_cnt_d = PCW'(1);
          fill_d    = plen_eff - PCW'(1);
          adv_d     = 1'b1;
        end
        state_d = spr_pkg::ST_SEL;
      end

      spr_pkg::ST_SEL: begin
        if (rep_k_q < rep_cnt_q) begin
          ctrl_o.rep_re = 1'b1;
          src_d         = spr_pkg::SRC_REP;
          last_d        = (rep_k_inc == rep_cnt_q) && (win_cnt_q == '0) && !word_pend_q;
          state_d       = spr_pkg::ST_WAIT;
        end else if (win_k_q < win_cnt_q) begin
          ctrl_o.win_re = 1'b1;
          src_d         = spr_pkg::SRC_WIN;
          last_d        = (win_k_inc == win_cnt_q) && !word_pend_q;
          state_d       = spr_pkg::ST_WAIT;
        end else if (word_pend_q) begin
          src_d   = spr_pkg::SRC_WORD;
          last_d  = 1'b1;
          state_d = spr_pkg::ST_WAIT;
        end else begin
          if (adv_q) begin
            head_d = head_adv;
          end
          state_d = spr_pkg::ST_IDLE;
        end
      end

      spr_pkg::ST_WAIT: begin
        // Hold the read data until the output register has room
        if (out_free_i) begin
          push_o = 1'b1;
          case (src_q)
            spr_pkg::SRC_REP:  rep_k_d     = rep_k_inc;
            spr_pkg::SRC_WIN:  win_k_d     = win_k_inc;
            spr_pkg::SRC_WORD: word_pend_d = 1'b0;
            default: ;
          endcase
          if (last_q) begin
            if (adv_q) begin
              head_d = head_adv;
            end
            state_d = spr_pkg::ST_IDLE;
          end else begin
            state_d = spr_pkg::ST_SEL;
          end
        end
      end

      default: state_d = spr_pkg::ST_IDLE;
    endcase

    if (cfg_we_i) begin
      case (spr_pkg::cfg_idx_e'(cfg_idx_i))
        spr_pkg::CFG_PLEN: begin
          plen_d = cfg_data_i;
          fill_d = '0;
        end
        spr_pkg::CFG_RLEN: rlen_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spr_pkg::ST_IDLE;
      src_q       <= spr_pkg::SRC_REP;
      plen_q      <= '0;
      rlen_q      <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      ins_q       <= 1'b0;
      win_k_q     <= '0;
      win_cnt_q   <= '0;
      rep_k_q     <= '0;
      rep_cnt_q   <= '0;
      word_pend_q <= 1'b0;
      flush_q     <= 1'b0;
      adv_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_q       <= src_d;
      plen_q      <= plen_d;
      rlen_q      <= rlen_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      ins_q       <= ins_d;
      win_k_q     <= win_k_d;
      win_cnt_q   <= win_cnt_d;
      rep_k_q     <= rep_k_d;
      rep_cnt_q   <= rep_cnt_d;
      word_pend_q <= word_pend_d;
      flush_q     <= flush_d;
      adv_q       <= adv_d;
      last_q      <= last_d;
    end
  end

  assign in_ready_o = (state_q == spr_pkg::ST_IDLE);
  assign last_o     = last_q;
  assign flush_o    = flush_q;
  assign head_o     = head_q;
  assign pat_idx_o  = win_k_q[PIW-1:0];
  assign rep_idx_o  = rep_k_q[RIW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/stream_pattern_replace_unit.sv
// Top level of the stream pattern replace block: ports, output register,
// assertions. Depends on spr_pkg, spr_seq and spr_dp.
`default_nettype none

// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata: word[31:0], slot[35:32]; tuser: func[1:0]
// m_axis    out  tvalid/tready         tdata: value[31:0]; tlast: last; tuser: final_flush
// cfg       in   cfg_we_i (no wait)    cfg_idx_i: 0 pattern_length, 1 replacement_length
//
// Steps: table writes and elements that do not complete the window are taken in
// the idle state. A completed window of P words is compared word by word (one
// window read and one pattern read per word through the single comparator),
// then a decide step, then each emitted beat is read, then pushed. A mismatch
// emits the oldest window word, a match the R replacement words, or none with
// an empty replacement. End of sequence and empty-pattern elements read and push
// each beat the same way; an end of sequence with nothing to flush emits none.
// Reset: control state clears at once; the memories need no clearing pass and
// hold garbage until written. Stalls: a full output register holds the beat
// in the read stage and the sequencer waits there.

module stream_pattern_replace_unit #(
  parameter int unsigned MAX_PATTERN     = 16,
  parameter int unsigned MAX_REPLACEMENT = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration
  input  wire                                 cfg_we_i,
  input  wire  [0:0]                          cfg_idx_i,
  input  wire  [spr_pkg::LEN_W-1:0]           cfg_data_i,
  // input beats
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [spr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // word[31:0], slot[35:32]
  input  wire  [spr_pkg::FUNC_W-1:0]          s_axis_tuser,  // func[1:0]
  // result beats
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic signed [spr_pkg::WORD_W-1:0]   m_axis_tdata,  // value[31:0]
  output logic                                m_axis_tlast,
  output logic [0:0]                          m_axis_tuser   // final_flush[0]
);

  localparam int unsigned PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PCW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RIW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  spr_pkg::ctrl_t ctrl;
  spr_pkg::func_e in_func;

  logic signed [spr_pkg::WORD_W-1:0] in_word;
  logic [spr_pkg::SLOT_W-1:0]        in_slot;

  logic [PIW-1:0] head;
  logic [PCW-1:0] win_off;
  logic [PIW-1:0] pat_idx;
  logic [RIW-1:0] rep_idx;
  logic           match;
  logic           push;
  logic           beat_last;
  logic           beat_flush;
  logic signed [spr_pkg::WORD_W-1:0] beat_value;

  logic out_free;
  logic m_valid_q, m_valid_d;
  logic signed [spr_pkg::WORD_W-1:0] m_data_q;
  logic m_last_q;
  logic m_flush_q;

  assign in_word = s_axis_tdata[spr_pkg::WORD_W-1:0];
  assign in_slot = s_axis_tdata[spr_pkg::WORD_W +: spr_pkg::SLOT_W];
  assign in_func = spr_pkg::func_e'(s_axis_tuser);

  spr_seq #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (in_func),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .push_o     (push),
    .last_o     (beat_last),
    .flush_o    (beat_flush),
    .match_i    (match),
    .ctrl_o     (ctrl),
    .head_o     (head),
    .win_off_o  (win_off),
    .pat_idx_o  (pat_idx),
    .rep_idx_o  (rep_idx)
  );

  spr_dp #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_dp (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .head_i    (head),
    .win_off_i (win_off),
    .pat_idx_i (pat_idx),
    .rep_idx_i (rep_idx),
    .slot_i    (in_slot),
    .word_i    (in_word),
    .match_o   (match),
    .value_o   (beat_value)
  );

  // Output register: take a new beat when empty or draining this cycle
  assign out_free  = !m_valid_q || m_axis_tready;
  assign m_valid_d = push ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_data_q  <= beat_value;
      m_last_q  <= beat_last;
      m_flush_q <= beat_flush;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tlast    = m_last_q;
  assign m_axis_tuser[0] = m_flush_q;

  // Never overwrite a beat that is still waiting downstream
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!m_valid_q || m_axis_tready))
    else $error("beat pushed into a full output register");

  // Table writes produce no beat
  a_table_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (in_func == spr_pkg::FN_WR_PAT || in_func == spr_pkg::FN_WR_REP)) |=> !push)
    else $error("table write produced a beat");

  // End of sequence always runs the emission sequencer before taking more
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && in_func == spr_pkg::FN_END) |=> !s_axis_tready)
    else $error("input taken right after end of sequence");

endmodule

`default_nettype wire

FILE: test/spr_rewrite_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the stream pattern replace block: watches the config port and both
// streams, predicts the rewritten words and compares them. Depends on spr_pkg.

module spr_rewrite_checker
  import spr_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire  [0:0]              cfg_idx_i,
  input  wire  [LEN_W-1:0]        cfg_data_i,
  input  wire                     s_axis_tvalid,
  input  wire                     s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]   s_axis_tdata,  // word[31:0], slot[35:32]
  input  wire  [FUNC_W-1:0]       s_axis_tuser,  // func[1:0]
  input  wire                     m_axis_tvalid,
  input  wire                     m_axis_tready,
  input  wire  [WORD_W-1:0]       m_axis_tdata,  // value[31:0]
  input  wire                     m_axis_tlast,
  input  wire  [0:0]              m_axis_tuser,  // final_flush[0]
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned MAX_BURST = DEPTH + 1;
  localparam int          MAX_SHOWN = 10;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
    logic              flush;
  } rewrite_beat_t;

  rewrite_beat_t     rewrite_q[$];
  logic [WORD_W-1:0] window_words [DEPTH];
  logic [WORD_W-1:0] pattern_words [DEPTH];
  logic [WORD_W-1:0] replace_words [DEPTH];
  int unsigned       window_fill;
  int unsigned       pattern_len_reg;
  int unsigned       replace_len_reg;
  logic              front_done;

  function automatic int unsigned clamp_len(int unsigned len);
    return (len > DEPTH) ? DEPTH : len;
  endfunction

  // Work out the beats caused by one input beat and queue them in order.
  task automatic rewrite_step(func_e fn, logic [WORD_W-1:0] word, logic [SLOT_W-1:0] slot);
    logic [WORD_W-1:0] burst_value [MAX_BURST];
    logic              burst_flush [MAX_BURST];
    int                n;
    int unsigned       k;
    int unsigned       plen;
    int unsigned       rlen;
    logic              same;
    n    = 0;
    plen = clamp_len(pattern_len_reg);
    rlen = clamp_len(replace_len_reg);
    case (fn)
      FN_WR_PAT: pattern_words[slot] = word;
      FN_WR_REP: replace_words[slot] = word;
      FN_END: begin
        if (plen == 0 && !front_done) begin
          for (k = 0; k < rlen; k++) begin
            burst_value[n] = replace_words[k];
            burst_flush[n] = 1'b1;
            n++;
          end
        end
        for (k = 0; k < window_fill; k++) begin
          burst_value[n] = window_words[k];
          burst_flush[n] = 1'b1;
          n++;
        end
        window_fill = 0;
        front_done  = 1'b0;
      end
      default: begin
        if (plen == 0) begin
          if (!front_done) begin
            for (k = 0; k < rlen; k++) begin
              burst_value[n] = replace_words[k];
              burst_flush[n] = 1'b0;
              n++;
            end
            front_done = 1'b1;
          end
          burst_value[n] = word;
          burst_flush[n] = 1'b0;
          n++;
        end else begin
          if (window_fill >= plen) window_fill = 0;
          window_words[window_fill] = word;
          window_fill++;
          if (window_fill == plen) begin
            same = 1'b1;
            for (k = 0; k < plen; k++) begin
              if (window_words[k] != pattern_words[k]) same = 1'b0;
            end
            if (same) begin
              for (k = 0; k < rlen; k++) begin
                burst_value[n] = replace_words[k];
                burst_flush[n] = 1'b0;
                n++;
              end
              window_fill = 0;
            end else begin
              burst_value[n] = window_words[0];
              burst_flush[n] = 1'b0;
              n++;
              for (k = 0; k + 1 < plen; k++) window_words[k] = window_words[k+1];
              window_fill = plen - 1;
            end
          end
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      rewrite_q.push_back('{value: burst_value[i], last: (i == n - 1), flush: burst_flush[i]});
    end
  endtask

  task automatic note_mismatch(string what, rewrite_beat_t exp_beat);
    if (fail_count_o < MAX_SHOWN) begin
      $display("%0t: %s: expected value %h last %b flush %b, got value %h last %b flush %b",
               $realtime, what, exp_beat.value, exp_beat.last, exp_beat.flush,
               m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rewrite_beat_t exp_beat;
    if (!rst_ni) begin
      rewrite_q.delete();
      window_fill     = 0;
      pattern_len_reg = 0;
      replace_len_reg = 0;
      front_done      = 1'b0;
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PLEN: begin
            pattern_len_reg = cfg_data_i;
            window_fill     = 0;
          end
          default: replace_len_reg = cfg_data_i;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rewrite_step(func_e'(s_axis_tuser), s_axis_tdata[WORD_W-1:0],
                     s_axis_tdata[WORD_W +: SLOT_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (rewrite_q.size() == 0) begin
          exp_beat = '0;
          note_mismatch("beat with nothing expected", exp_beat);
        end else begin
          exp_beat = rewrite_q.pop_front();
          if (exp_beat.value != m_axis_tdata || exp_beat.last != m_axis_tlast ||
              exp_beat.flush != m_axis_tuser[0]) begin
            note_mismatch("result mismatch", exp_beat);
          end
        end
      end
      pending_o = rewrite_q.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for stream_pattern_replace_unit: clock, reset, stimulus and verdict.
// Depends on spr_pkg, the block and spr_rewrite_checker.

module tb_top;
  import spr_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  // Worst item: full 16-word compare, decide, then 16 replacement beats, each read
  // then pushed; round up for the drain before a config write.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned NUM_PHASES   = 4;

  localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] ALL_ONE = 32'hFFFF_FFFF;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [0:0]               cfg_idx_i;
  logic [LEN_W-1:0]         cfg_data_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_TDATA_W-1:0]    s_axis_tdata;   // word[31:0], slot[35:32]
  logic [FUNC_W-1:0]        s_axis_tuser;   // func[1:0]
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [WORD_W-1:0]        m_axis_tdata;   // value[31:0]
  logic                     m_axis_tlast;
  logic [0:0]               m_axis_tuser;   // final_flush[0]

  int                       fail_count;
  int                       pending_beats;
  int unsigned              cycle_count;
  int unsigned              gap_pct;        // chance per beat slot that the sender idles
  int unsigned              stall_pct;      // chance per cycle that the receiver stalls

  // Our own copy of the pattern, so well-formed runs can be built from it.
  logic [WORD_W-1:0]        pattern_shadow [TABLE_DEPTH];
  int unsigned              active_plen;

  stream_pattern_replace_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  spr_rewrite_checker u_rewrite_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: drop tready at random according to the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mix of small values (so noise partly matches the pattern), the extremes,
  // and full-range random words.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(3))
      0: return WORD_W'($urandom_range(3));
      1: begin
        case ($urandom_range(3))
          0: return INT_MIN;
          1: return INT_MAX;
          2: return '0;
          default: return ALL_ONE;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Present one beat and hold it until accepted. The idle gap lowers tvalid
  // first, so tvalid stays high between back-to-back beats.
  task automatic send_beat(func_e fn, logic [WORD_W-1:0] word, logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {{(IN_TDATA_W-SLOT_W-WORD_W){1'b0}}, slot, word};
    if (fn == FN_WR_PAT) pattern_shadow[slot] = word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Elements carry a random slot field; the block must ignore it.
  task automatic send_elem(logic [WORD_W-1:0] word);
    send_beat(FN_ELEM, word, SLOT_W'($urandom_range(15)));
  endtask

  task automatic send_end();
    send_beat(FN_END, $urandom, SLOT_W'($urandom_range(15)));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [LEN_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_PLEN) active_plen = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
  endtask

  // Hold the sender until every predicted beat has come out.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_beats != 0);
  endtask

  // Same, then let any silent work (a match with an empty replacement) finish
  // before the registers are touched.
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One random unit of stimulus, mostly the pattern itself among noise.
  task automatic random_unit();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    if (pick < 55) begin
      repeat ($urandom_range(2)) send_elem(pick_word());
      if (active_plen == 0) begin
        repeat ($urandom_range(1, 3)) send_elem(pick_word());
      end else begin
        for (int k = 0; k < active_plen; k++) send_elem(pattern_shadow[k]);
      end
    end else if (pick < 70) begin
      // Broken run: a prefix of the pattern, then a stray word.
      span = (active_plen > 1) ? $urandom_range(active_plen - 1) : 0;
      for (int k = 0; k < span; k++) send_elem(pattern_shadow[k]);
      send_elem(pick_word());
    end else if (pick < 82) begin
      send_elem(pick_word());
    end else if (pick < 92) begin
      send_end();
    end else begin
      send_beat($urandom_range(1) ? FN_WR_PAT : FN_WR_REP, pick_word(),
                SLOT_W'($urandom_range(15)));
    end
  endtask

  initial begin
    int unsigned plen_set  [NUM_PHASES];
    int unsigned rlen_set  [NUM_PHASES];
    int unsigned plen_eff;
    int unsigned rlen_eff;
    int unsigned units;

    // Register settings per phase: empty, full and over-range lengths included.
    plen_set = '{3, 0, 2, 31};
    rlen_set = '{2, 5, 20, 0};

    gap_pct       = 0;
    stall_pct     = 0;
    active_plen   = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_PLEN;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FN_ELEM;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, light idling on both sides.
    gap_pct   = 9;
    stall_pct = 9;
    write_reg(CFG_PLEN, 3);
    write_reg(CFG_RLEN, 2);
    send_beat(FN_WR_PAT, INT_MIN, 0);
    send_beat(FN_WR_PAT, INT_MAX, 1);
    send_beat(FN_WR_PAT, ALL_ONE, 2);
    send_beat(FN_WR_PAT, 32'h5555_5555, 15);
    send_beat(FN_WR_REP, '0, 0);
    send_beat(FN_WR_REP, ALL_ONE, 1);
    send_beat(FN_WR_REP, 32'hAAAA_AAAA, 15);
    // Exact match: two replacement words come out.
    send_elem(INT_MIN);
    send_elem(INT_MAX);
    send_elem(ALL_ONE);
    // Near misses pass the oldest word on, then the flush empties the window.
    send_elem(32'd7);
    send_elem(INT_MIN);
    send_elem(INT_MAX);
    send_elem('0);
    send_end();
    // Empty pattern: replacement goes in front of the first element, and an
    // empty sequence still gets it at end of sequence.
    settle();
    write_reg(CFG_PLEN, 0);
    send_elem(32'd1);
    send_elem(32'd2);
    send_end();
    send_end();
    // Empty replacement: the matched words vanish.
    settle();
    write_reg(CFG_PLEN, 3);
    write_reg(CFG_RLEN, 0);
    send_elem(INT_MIN);
    send_elem(INT_MAX);
    send_elem(ALL_ONE);
    send_elem(INT_MIN);
    send_elem(INT_MAX);
    // Rewriting the pattern length drops the two buffered words unseen.
    settle();
    write_reg(CFG_PLEN, 3);
    send_elem(ALL_ONE);
    send_end();

    // Random phases, each with its own lengths and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 82; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 82; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      write_reg(CFG_PLEN, LEN_W'(plen_set[p]));
      write_reg(CFG_RLEN, LEN_W'(rlen_set[p]));
      plen_eff = (plen_set[p] > TABLE_DEPTH) ? TABLE_DEPTH : plen_set[p];
      rlen_eff = (rlen_set[p] > TABLE_DEPTH) ? TABLE_DEPTH : rlen_set[p];
      // Fill every table entry the block may read with this setting.
      for (int k = 0; k < plen_eff; k++) send_beat(FN_WR_PAT, pick_word(), SLOT_W'(k));
      for (int k = 0; k < rlen_eff; k++) send_beat(FN_WR_REP, pick_word(), SLOT_W'(k));
      units = (plen_eff >= 8) ? 1 : 3;
      for (int u = 0; u < units; u++) begin
        // Halfway through, hold the sender until the output side catches up.
        if (u == units / 2) wait_results();
        random_unit();
      end
      send_end();
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/spr_pkg.sv
hw/rtl/spr_dp.sv
hw/rtl/spr_seq.sv
hw/rtl/stream_pattern_replace_unit.sv
test/spr_rewrite_checker.sv
test/tb_top.sv
